// ----- src/pdea_pkg.sv -----
// Package: payload types, efficiency curve tables and shared constants.
package pdea_pkg;

  localparam int unsigned EnergyW = 24;
  localparam int unsigned WlW     = 16;
  localparam int unsigned EffW    = 16;
  localparam int unsigned SumW    = 40;
  localparam int unsigned CntW    = 16;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned UsedW   = 7;
  localparam int unsigned NumSeg  = 16;
  localparam int unsigned QuotW   = 37;
  localparam int unsigned RecipW  = 29;
  localparam logic [QuotW-1:0] WlNumer = 37'd79360000000;
  localparam logic [SumW-1:0]  EMax    = {SumW{1'b1}};
  localparam logic [32:0]      Two32   = 33'h1_0000_0000;

  localparam logic FuncPhoton = 1'b0;
  localparam logic FuncEvent  = 1'b1;

  typedef struct packed {
    logic                  func;
    logic                  is_optical;
    logic                  moving_outward;
    logic                  on_front_face;
    logic [EnergyW-1:0]    photon_energy_uev;
    logic [5:0]            channel;
    logic [15:0]           random_draw;
  } in_word_t;

  typedef struct packed {
    logic                  kill_track;
    logic                  photon_recorded;
    logic                  accepted;
    logic [EffW-1:0]       efficiency;
    logic                  new_slot;
    logic [SlotW-1:0]      slot_index;
    logic [SumW-1:0]       energy_sum_uev;
    logic [CntW-1:0]       photon_count;
  } out_word_t;

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StInterp,
    StUpdate
  } state_e;

  // Breakpoint wavelength in whole nm.
  function automatic logic [9:0] bp_nm(input logic [4:0] i);
    logic [9:0] r;
    begin
      unique case (i)
        5'd0: r = 10'd303;   5'd1: r = 10'd332;   5'd2: r = 10'd370;
        5'd3: r = 10'd411;   5'd4: r = 10'd451;   5'd5: r = 10'd467;
        5'd6: r = 10'd480;   5'd7: r = 10'd491;   5'd8: r = 10'd510;
        5'd9: r = 10'd530;   5'd10: r = 10'd560;  5'd11: r = 10'd580;
        5'd12: r = 10'd614;  5'd13: r = 10'd650;  5'd14: r = 10'd691;
        5'd15: r = 10'd751;  5'd16: r = 10'd930;
        default: r = 10'd930;
      endcase
      return r;
    end
  endfunction

  // Breakpoint efficiency, Q0.16.
  function automatic logic [15:0] bp_eff(input logic [4:0] i);
    logic [15:0] r;
    begin
      unique case (i)
        5'd0: r = 16'd0;      5'd1: r = 16'd9332;   5'd2: r = 16'd14123;
        5'd3: r = 16'd17452;  5'd4: r = 16'd19661;  5'd5: r = 16'd20381;
        5'd6: r = 16'd20554;  5'd7: r = 16'd20455;  5'd8: r = 16'd19785;
        5'd9: r = 16'd18990;  5'd10: r = 16'd17177; 5'd11: r = 16'd15565;
        5'd12: r = 16'd13704; 5'd13: r = 16'd11718; 5'd14: r = 16'd9804;
        5'd15: r = 16'd7196;  5'd16: r = 16'd0;
        default: r = 16'd0;
      endcase
      return r;
    end
  endfunction

  // Segment width reciprocal, ceil(2^32 / width in nm).
  function automatic logic [RecipW-1:0] seg_recip(input logic [4:0] i);
    logic [RecipW-1:0] r;
    begin
      unique case (i)
        5'd0:  r = RecipW'((Two32 + 33'd28) / 33'd29);
        5'd1:  r = RecipW'((Two32 + 33'd37) / 33'd38);
        5'd2:  r = RecipW'((Two32 + 33'd40) / 33'd41);
        5'd3:  r = RecipW'((Two32 + 33'd39) / 33'd40);
        5'd4:  r = RecipW'((Two32 + 33'd15) / 33'd16);
        5'd5:  r = RecipW'((Two32 + 33'd12) / 33'd13);
        5'd6:  r = RecipW'((Two32 + 33'd10) / 33'd11);
        5'd7:  r = RecipW'((Two32 + 33'd18) / 33'd19);
        5'd8:  r = RecipW'((Two32 + 33'd19) / 33'd20);
        5'd9:  r = RecipW'((Two32 + 33'd29) / 33'd30);
        5'd10: r = RecipW'((Two32 + 33'd19) / 33'd20);
        5'd11: r = RecipW'((Two32 + 33'd33) / 33'd34);
        5'd12: r = RecipW'((Two32 + 33'd35) / 33'd36);
        5'd13: r = RecipW'((Two32 + 33'd40) / 33'd41);
        5'd14: r = RecipW'((Two32 + 33'd59) / 33'd60);
        default: r = RecipW'((Two32 + 33'd178) / 33'd179);
      endcase
      return r;
    end
  endfunction

endpackage

// ----- src/pdea_divider.sv -----
// Radix-2 restoring divider: one quotient bit per cycle.
module pdea_divider import pdea_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [EnergyW-1:0] divisor_i,
  output logic               done_o,
  output logic [QuotW-1:0]   quot_o
);

  localparam int unsigned CntBits = $clog2(QuotW + 1);

  logic [QuotW-1:0]   quot_q, quot_d;
  logic [EnergyW:0]   rem_q, rem_d;
  logic [EnergyW-1:0] dvs_q, dvs_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [EnergyW:0]   trial;
  logic [EnergyW+1:0] diff;

  assign trial = {rem_q[EnergyW-1:0], quot_q[QuotW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = WlNumer;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntBits'(QuotW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift in one dividend bit, subtract when it fits.
      if (!diff[EnergyW+1]) begin
        rem_d  = diff[EnergyW:0];
        quot_d = {quot_q[QuotW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[QuotW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- src/photon_detect_efficiency_accumulator.sv -----
// Top level: photon efficiency test and per-channel hit accumulation.
//
// Input channel (in_valid_i / in_stall_o / in_word_i) takes one photon or
// new-event word at a time. Output channel (out_valid_o / out_stall_i /
// out_word_o) returns exactly one result word per input word.
// A photon on the efficiency path takes these steps in order: a registered
// start pulse starts the divider, which forms the wavelength, 1240 eV*nm
// over the energy, one bit a cycle over 37 quotient bits; the interpolation
// sum is registered, then scaled by the segment width with a reciprocal
// multiply while the channel entry is read, the entry is written back, and
// the word moves into the output register once that is free. Words that
// need no efficiency (new event, non-optical, reflection, side entry) skip
// those steps. The next word is taken once the last result has moved into
// the output register; one word is worked on at a time.
// Per-channel sums live in a synchronous memory (registered read). A seen
// bit per channel, held in flops, marks entries written this event; a
// new-event word clears all seen bits and the slot counter at once.
// Reset clears control, seen bits and the slot counter; memory contents
// are left as they are, and an entry is used only once written this event.
// While the receiver stalls, hold the output word; the next result waits.
module photon_detect_efficiency_accumulator import pdea_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  state_e     state_q, state_d;
  in_word_t   cur_q;
  logic       busy_q;
  logic       res_ready_q;
  out_word_t  res_q;
  logic       out_valid_q;
  out_word_t  out_q;
  logic [NUM_CHANNELS-1:0] seen_q;
  logic [UsedW-1:0] used_q;
  logic [EffW-1:0]  eff_q;
  logic signed [34:0] num_q;
  logic [4:0]  seg_q;
  logic        div_start, div_done;
  logic [QuotW-1:0] quot;

  // accumulator memory: {slot, energy, count}
  logic [SlotW+SumW+CntW-1:0] mem [NUM_CHANNELS];
  logic [SlotW+SumW+CntW-1:0] rd_q;
  logic                       ch_ok;
  logic [ChW-1:0]             ch_idx;

  assign ch_ok  = ({5'b0, cur_q.channel} < 11'(NUM_CHANNELS));
  assign ch_idx = ChW'(cur_q.channel);

  logic take_in, take_out, need_eff;
  assign take_out  = out_valid_q && !out_stall_i;
  assign in_stall_o = busy_q;
  assign take_in   = in_valid_i && !busy_q;
  assign need_eff  = cur_q.func == FuncPhoton && cur_q.is_optical &&
                     !cur_q.moving_outward && cur_q.on_front_face;

  pdea_divider u_div (
    .clk_i, .rst_ni,
    .start_i  (div_start),
    .divisor_i(cur_q.photon_energy_uev),
    .done_o   (div_done),
    .quot_o   (quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (busy_q && !res_ready_q) state_d = need_eff ? StDivide : StIdle;
      StDivide: if (div_done) state_d = StInterp;
      StInterp: state_d = StUpdate;
      StUpdate: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  logic start_pend_q;
  assign div_start = start_pend_q;

  // segment lookup and interpolation numerator
  logic [WlW-1:0] wl;
  logic [4:0] seg;
  logic [15:0] den;
  logic [31:0] base;
  logic signed [16:0] slope, dx;
  logic signed [33:0] tilt;
  logic signed [34:0] num;
  always_comb begin
    wl = (quot > QuotW'(65535)) ? 16'hFFFF : quot[WlW-1:0];
    seg = 5'd15;
    for (int i = 15; i >= 1; i--) begin
      if (wl < {bp_nm(5'(i)), 6'b0}) seg = 5'(i - 1);
    end
    den   = {bp_nm(seg + 5'd1) - bp_nm(seg), 6'b0};
    base  = bp_eff(seg) * den;
    slope = $signed({1'b0, bp_eff(seg + 5'd1)}) - $signed({1'b0, bp_eff(seg)});
    dx    = $signed({1'b0, wl}) - $signed({1'b0, bp_nm(seg), 6'b0});
    tilt  = slope * dx;
    num   = $signed({3'b0, base}) + 35'(tilt);
  end

  // divide by segment width: drop the x64, then multiply by the width
  // reciprocal; a positive numerator stays below 2^27, so this is exact
  logic [EffW-1:0] eff_val;
  logic [21:0] num_lo;
  logic [50:0] prod;
  logic [18:0] qv;
  always_comb begin
    num_lo = num_q[27:6];
    prod   = num_lo * seg_recip(seg_q);
    qv     = prod[50:32];
    if (num_q <= 35'sd0 || cur_q.photon_energy_uev == '0) eff_val = '0;
    else if (qv > 19'd65535) eff_val = 16'hFFFF;
    else eff_val = qv[EffW-1:0];
  end

  // result assembly for the update step
  out_word_t upd;
  logic [SumW:0] sum;
  logic acc;
  always_comb begin
    upd = '0;
    upd.kill_track      = 1'b1;
    upd.photon_recorded = 1'b1;
    upd.efficiency      = eff_q;
    acc = {16'b0, cur_q.random_draw} <= {16'b0, eff_q};
    upd.accepted = acc;
    sum = {1'b0, rd_q[SumW+CntW-1:CntW]} + (SumW+1)'(cur_q.photon_energy_uev);
    if (acc && ch_ok) begin
      if (!seen_q[ch_idx]) begin
        upd.new_slot       = 1'b1;
        upd.slot_index     = used_q[SlotW-1:0];
        upd.energy_sum_uev = SumW'(cur_q.photon_energy_uev);
        upd.photon_count   = 16'd1;
      end else begin
        upd.slot_index     = rd_q[SlotW+SumW+CntW-1:SumW+CntW];
        upd.energy_sum_uev = sum[SumW] ? EMax : sum[SumW-1:0];
        upd.photon_count   = (rd_q[CntW-1:0] == 16'hFFFF) ? 16'hFFFF
                                                          : rd_q[CntW-1:0] + 16'd1;
      end
    end
  end

  // quick result for words that skip the efficiency path
  out_word_t quick;
  always_comb begin
    quick = '0;
    if (cur_q.func == FuncPhoton)
      quick.kill_track = !cur_q.is_optical || !cur_q.moving_outward;
  end

  always_ff @(posedge clk_i) begin
    if (take_in) cur_q <= in_word_i;
    if (state_q == StDivide && div_done) begin
      num_q <= num;
      seg_q <= seg;
    end
    if (state_q == StInterp) begin
      eff_q <= eff_val;
      rd_q  <= mem[ch_idx];
    end
    if (state_q == StUpdate && upd.accepted && ch_ok)
      mem[ch_idx] <= {upd.slot_index, upd.energy_sum_uev, upd.photon_count};
    if (state_q == StIdle && busy_q && !res_ready_q && !need_eff) res_q <= quick;
    if (state_q == StUpdate) res_q <= upd;
    if (res_ready_q && (!out_valid_q || take_out)) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      busy_q       <= 1'b0;
      res_ready_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      seen_q       <= '0;
      used_q       <= '0;
      start_pend_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      start_pend_q <= state_q == StIdle && busy_q && !res_ready_q && need_eff;
      if (take_in) busy_q <= 1'b1;
      if (state_q == StIdle && busy_q && !res_ready_q && !need_eff) begin
        res_ready_q <= 1'b1;
        if (cur_q.func == FuncEvent) begin
          seen_q <= '0;
          used_q <= '0;
        end
      end
      if (state_q == StUpdate) begin
        res_ready_q <= 1'b1;
        if (upd.new_slot) begin
          seen_q[ch_idx] <= 1'b1;
          if (used_q != 7'd127) used_q <= used_q + 7'd1;
        end
      end
      if (res_ready_q && (!out_valid_q || take_out)) begin
        res_ready_q <= 1'b0;
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (take_out) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> in_stall_o) else $error("input taken while working");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled word changed");
  a_eff_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StUpdate && cur_q.photon_energy_uev == '0 |-> eff_q == '0)
    else $error("zero energy gave nonzero efficiency");

endmodule
